// File: sv/device_address_table_defines.svh
// ----------------------------------------------------------------------------
// Device address table assertion macros
// Assertion helpers used by the table controller.
// ----------------------------------------------------------------------------
`ifndef DEVICE_ADDRESS_TABLE_DEFINES_SVH
`define DEVICE_ADDRESS_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/dat_pkg.sv
// ----------------------------------------------------------------------------
// Device address table package
// Types, codes and constants shared by the table modules.
// ----------------------------------------------------------------------------
package dat_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam logic [6:0] LIMIT_RESET = 7'd64;
	localparam logic [7:0] HIT_MAX = 8'd255;

	localparam logic [2:0] ACT_LOOKUP = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]        action;
		logic [47:0]       mac;
		logic signed [7:0] rssi;
		logic [15:0]       day_stamp;
		logic [16:0]       time_of_day;
		logic [5:0]        slot_index;
	} item_t;

	typedef struct packed {
		logic [7:0]        hits;
		logic              found;
		logic [6:0]        occupied;
		logic [47:0]       entry_mac;
		logic signed [7:0] entry_rssi;
		logic [15:0]       entry_day;
		logic [16:0]       entry_first;
		logic [16:0]       entry_last;
	} result_t;

	typedef struct packed {
		logic [47:0]       mac;
		logic signed [7:0] rssi;
		logic [7:0]        hits;
		logic [15:0]       day;
		logic [16:0]       first;
		logic [16:0]       last;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		WR_UPDATE,
		WR_NEW,
		WR_COPY
	} wr_src_t;

	typedef struct packed {
		logic    take_item;
		logic    rd_en;
		logic    wr_en;
		wr_src_t wr_src;
		logic    cap_hits;
		logic    set_found;
		logic    cap_entry;
		logic    publish;
	} dat_cmd_t;

	typedef struct packed {
		logic match;
		logic out_busy;
	} dat_status_t;

endpackage

// File: sv/device_address_table.sv
// ----------------------------------------------------------------------------
// Device address table
// Table of seen device addresses with lookup, insert, delete, clear and read.
// ----------------------------------------------------------------------------
// An item beat on the item channel carries one command; each item yields
// exactly one beat on the result channel. The block works on one item at a
// time: item_stall is high from acceptance until the result is registered.
// A scan or shift visits one stored entry per step through the one read port
// and the one write port of the entry memory. The result stays in an output
// register while the receiver stalls; the next item can be accepted
// meanwhile, and its own result waits until the previous one is taken.
// The table_limit register lies at address 0 of the APB port and should be
// written only while the block is idle. Reset empties the table at once
// (no clearing pass) and sets table_limit to 64.
// ----------------------------------------------------------------------------
module device_address_table #(
	parameter int TABLE_DEPTH = dat_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dat_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output dat_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import dat_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [6:0]    limit_q;
	logic [CW-1:0] eff_lim;
	dat_cmd_t      cmd;
	dat_status_t   status;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [6:0]    occ;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {25'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			limit_q <= pwdata[6:0];
		end
	end

	always_comb begin
		if (limit_q == 7'd0) begin
			eff_lim = CW'(1);
		end else if (32'(limit_q) > 32'(TABLE_DEPTH)) begin
			eff_lim = CW'(TABLE_DEPTH);
		end else begin
			eff_lim = CW'(limit_q);
		end
	end

	dat_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_action(item.action),
		.item_slot  (item.slot_index),
		.item_stall (item_stall),
		.eff_lim    (eff_lim),
		.status     (status),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.occ        (occ)
	);

	dat_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.occ         (occ),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result),
		.status      (status)
	);

endmodule

// File: sv/dat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/dat_dp.sv
// ----------------------------------------------------------------------------
// Device address table datapath
// Entry storage, address compare, entry update and the result register.
// ----------------------------------------------------------------------------
module dat_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dat_pkg::item_t                 item,
	input  dat_pkg::dat_cmd_t              cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic [6:0]                     occ,
	input  logic                           result_stall,
	output logic                           result_valid,
	output dat_pkg::result_t               result,
	output dat_pkg::dat_status_t           status
);
	import dat_pkg::*;

	item_t   item_q;
	entry_t  rd_entry;
	entry_t  upd_entry;
	entry_t  new_entry;
	entry_t  wr_entry;
	entry_t  entry_q;
	logic [ENTRY_W-1:0] rd_data;
	logic [7:0] hits_q;
	logic       found_q;
	result_t    res_q;
	logic       res_valid_q;

	dat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	always_comb begin
		upd_entry = rd_entry;
		upd_entry.rssi = item_q.rssi;
		upd_entry.last = item_q.time_of_day;
		if (rd_entry.hits != HIT_MAX) begin
			upd_entry.hits = rd_entry.hits + 8'd1;
		end
		new_entry.mac   = item_q.mac;
		new_entry.rssi  = item_q.rssi;
		new_entry.hits  = 8'd1;
		new_entry.day   = item_q.day_stamp;
		new_entry.first = item_q.time_of_day;
		new_entry.last  = item_q.time_of_day;
		case (cmd.wr_src)
			WR_UPDATE: wr_entry = upd_entry;
			WR_NEW:    wr_entry = new_entry;
			WR_COPY:   wr_entry = rd_entry;
			default:   wr_entry = rd_entry;
		endcase
	end

	assign status.match = (rd_entry.mac == item_q.mac);
	assign status.out_busy = res_valid_q && result_stall;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= item;
			entry_q <= '0;
		end else if (cmd.cap_entry) begin
			entry_q <= rd_entry;
		end
		if (cmd.publish) begin
			res_q.hits        <= hits_q;
			res_q.found       <= found_q;
			res_q.occupied    <= occ;
			res_q.entry_mac   <= entry_q.mac;
			res_q.entry_rssi  <= entry_q.rssi;
			res_q.entry_day   <= entry_q.day;
			res_q.entry_first <= entry_q.first;
			res_q.entry_last  <= entry_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.take_item) begin
				hits_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.cap_hits) begin
					hits_q <= upd_entry.hits;
				end else if (cmd.cap_entry) begin
					hits_q <= rd_entry.hits;
				end
				if (cmd.set_found || cmd.cap_hits || cmd.cap_entry) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.publish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result = res_q;
	assign result_valid = res_valid_q;

endmodule

// File: sv/dat_ctrl.sv
// ----------------------------------------------------------------------------
// Device address table controller
// Sequences scans and shifts over the entry store, one entry per step.
// ----------------------------------------------------------------------------
`include "device_address_table_defines.svh"

module dat_ctrl #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  logic [2:0]                         item_action,
	input  logic [5:0]                         item_slot,
	output logic                               item_stall,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   eff_lim,
	input  dat_pkg::dat_status_t               status,
	output dat_pkg::dat_cmd_t                  cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
	output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
	output logic [6:0]                         occ
);
	import dat_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_L_RD,
		ST_L_CHK,
		ST_I_RD,
		ST_I_WR,
		ST_D_RD,
		ST_D_CHK,
		ST_S_RD,
		ST_S_WR,
		ST_R_RD,
		ST_R_WAIT,
		ST_FINISH
	} state_t;

	state_t      state_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] occ_q;
	logic [2:0]  act_q;
	logic [5:0]  idx_q;
	logic [CW-1:0] ptr_dn;
	logic [CW-1:0] ptr_up;
	logic        last_pair;

	assign ptr_dn = ptr_q - CW'(1);
	assign ptr_up = ptr_q + CW'(1);
	assign last_pair = (ptr_up >= occ_q);

	assign item_stall = (state_q != ST_IDLE);
	assign occ = 7'(occ_q);
	assign wr_addr = ptr_q[AW-1:0];

	always_comb begin
		cmd = '0;
		cmd.wr_src = WR_COPY;
		rd_addr = ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: cmd.take_item = item_valid;
			ST_L_RD: cmd.rd_en = (ptr_q != occ_q);
			ST_L_CHK: begin
				cmd.wr_en = status.match;
				cmd.wr_src = WR_UPDATE;
				cmd.cap_hits = status.match;
			end
			ST_I_RD: begin
				rd_addr = ptr_dn[AW-1:0];
				cmd.rd_en = (ptr_q != '0);
				cmd.wr_en = (ptr_q == '0);
				cmd.wr_src = WR_NEW;
			end
			ST_I_WR: cmd.wr_en = 1'b1;
			ST_D_RD: cmd.rd_en = (ptr_q != occ_q);
			ST_D_CHK: cmd.set_found = status.match;
			ST_S_RD: begin
				rd_addr = ptr_up[AW-1:0];
				cmd.rd_en = !last_pair;
			end
			ST_S_WR: cmd.wr_en = 1'b1;
			ST_R_RD: begin
				rd_addr = AW'(idx_q);
				cmd.rd_en = 1'b1;
			end
			ST_R_WAIT: cmd.cap_entry = 1'b1;
			ST_FINISH: cmd.publish = !status.out_busy;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			occ_q <= '0;
			act_q <= ACT_LOOKUP;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (occ_q > eff_lim) begin
						occ_q <= eff_lim;
					end
					if (item_valid) begin
						act_q <= item_action;
						idx_q <= item_slot;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					ptr_q <= '0;
					case (act_q)
						ACT_LOOKUP: state_q <= ST_L_RD;
						ACT_INSERT: begin
							ptr_q <= (occ_q < eff_lim) ? occ_q : eff_lim - CW'(1);
							state_q <= ST_I_RD;
						end
						ACT_DELETE: state_q <= ST_D_RD;
						ACT_CLEAR: begin
							occ_q <= '0;
							state_q <= ST_FINISH;
						end
						ACT_READ: begin
							if (32'(idx_q) < 32'(eff_lim) && 32'(idx_q) < 32'(occ_q)) begin
								state_q <= ST_R_RD;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						default: state_q <= ST_FINISH;
					endcase
				end
				ST_L_RD: state_q <= (ptr_q == occ_q) ? ST_FINISH : ST_L_CHK;
				ST_L_CHK: begin
					ptr_q <= ptr_up;
					state_q <= ST_L_RD;
				end
				ST_I_RD: begin
					if (ptr_q == '0) begin
						if (occ_q < eff_lim) begin
							occ_q <= occ_q + CW'(1);
						end
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_I_WR;
					end
				end
				ST_I_WR: begin
					ptr_q <= ptr_dn;
					state_q <= ST_I_RD;
				end
				ST_D_RD: state_q <= (ptr_q == occ_q) ? ST_FINISH : ST_D_CHK;
				ST_D_CHK: begin
					if (status.match) begin
						state_q <= ST_S_RD;
					end else begin
						ptr_q <= ptr_up;
						state_q <= ST_D_RD;
					end
				end
				ST_S_RD: begin
					if (last_pair) begin
						occ_q <= occ_q - CW'(1);
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_S_WR;
					end
				end
				ST_S_WR: begin
					ptr_q <= ptr_up;
					state_q <= ST_S_RD;
				end
				ST_R_RD: state_q <= ST_R_WAIT;
				ST_R_WAIT: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DAT_ASSERT_IMPLY(a_occ_in_limit, clk, arst_n, state_q != ST_IDLE, occ_q <= eff_lim)
	`DAT_ASSERT_IMPLY(a_no_read_on_write, clk, arst_n, cmd.wr_en, !cmd.rd_en)
	`DAT_ASSERT_NEXT(a_publish_to_idle, clk, arst_n, cmd.publish, state_q == ST_IDLE)

endmodule
